/* sv/tlp_pkg.sv */
// Shared types and constants for the transition list text parser.
package tlp_pkg;

	// Character and result widths
	localparam int CHAR_W      = 8;
	localparam int NODE_OUT_W  = 16;
	localparam int STATUS_W    = 2;

	// Condition store shared by the front count and the back buffer
	localparam int STORE_DEPTH = 16;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;

	// Command queue between front and back
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = 2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_RECORD   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	// Character codes the lexer tests for
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_TXT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TXT_HI = 8'h7E;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

	// Command kinds sent from front to back
	typedef enum logic [1:0] {
		CMD_COND = 2'd0,
		CMD_END  = 2'd1,
		CMD_ERR  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [STATUS_W-1:0]     status;
		logic [CHAR_W-1:0]       cond;
		logic [NODE_OUT_W-1:0]   src;
		logic [NODE_OUT_W-1:0]   dest;
	} cmd_t;

endpackage

/* sv/tlp_front.sv */
// Lexer front end: classifies characters, accumulates numbers, issues commands.
module tlp_front #(
	parameter int MAX_CONDS = 16,
	parameter int NODE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  logic [7:0]            char_code,
	input  logic                  q_full,
	output logic                  q_push,
	output tlp_pkg::cmd_t         q_cmd
);
	import tlp_pkg::*;

	localparam int CAP = (MAX_CONDS < STORE_DEPTH) ? MAX_CONDS : STORE_DEPTH;

	typedef enum logic [13:0] {
		S_LINE   = 14'h0001,
		S_SRC    = 14'h0002,
		S_DASH1  = 14'h0004,
		S_QOPEN  = 14'h0008,
		S_QCHAR  = 14'h0010,
		S_QCLOSE = 14'h0020,
		S_COMMA  = 14'h0040,
		S_CODE   = 14'h0080,
		S_DASH2  = 14'h0100,
		S_DST    = 14'h0200,
		S_SEMI   = 14'h0400,
		S_TAIL   = 14'h0800,
		S_CMT    = 14'h1000,
		S_ERR    = 14'h2000
	} lex_state_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_text(input logic [CHAR_W-1:0] c);
		return (c >= CH_TXT_LO) && (c <= CH_TXT_HI) && !((c >= CH_LBRACE) && (c <= CH_RBRACE));
	endfunction

	function automatic lex_state_t next_state(input lex_state_t s, input logic [CHAR_W-1:0] c);
		lex_state_t n;
		n = S_ERR;
		unique case (s)
			S_LINE: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_NL) n = S_LINE;
				else if (is_digit(c)) n = S_SRC;
				else if (c == CH_HASH) n = S_CMT;
			end
			S_SRC: begin
				if (is_digit(c)) n = S_SRC;
				else if (c == CH_DASH) n = S_DASH1;
			end
			S_DASH1, S_COMMA: begin
				if (c == CH_QUOTE) n = S_QOPEN;
				else if (is_digit(c)) n = S_CODE;
			end
			S_QOPEN: begin
				if (is_text(c)) n = S_QCHAR;
			end
			S_QCHAR: begin
				if (c == CH_QUOTE) n = S_QCLOSE;
			end
			S_QCLOSE: begin
				if (c == CH_COMMA) n = S_COMMA;
				else if (c == CH_DASH) n = S_DASH2;
			end
			S_CODE: begin
				if (c == CH_COMMA) n = S_COMMA;
				else if (is_digit(c)) n = S_CODE;
				else if (c == CH_DASH) n = S_DASH2;
			end
			S_DASH2: begin
				if (is_digit(c)) n = S_DST;
			end
			S_DST: begin
				if (is_digit(c)) n = S_DST;
				else if (c == CH_SEMI) n = S_SEMI;
			end
			S_SEMI, S_TAIL: begin
				if (c == CH_NL) n = S_LINE;
				else if (c == CH_SPACE || c == CH_TAB) n = S_TAIL;
				else if (c == CH_HASH) n = S_CMT;
			end
			S_CMT: begin
				if (c == CH_NL) n = S_LINE;
				else if (is_text(c)) n = S_CMT;
			end
			default: n = S_ERR;
		endcase
		return n;
	endfunction

	lex_state_t             state_q;
	lex_state_t             nxt;
	logic [NODE_BITS-1:0]   src_q;
	logic [NODE_BITS-1:0]   dst_q;
	logic [CHAR_W-1:0]      cur_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NODE_BITS-1:0]   src_nxt;
	logic [NODE_BITS-1:0]   dst_nxt;
	logic [CHAR_W-1:0]      cur_nxt;
	logic [NODE_BITS+NODE_OUT_W-1:0] src_ext;
	logic [NODE_BITS+NODE_OUT_W-1:0] dst_ext;
	logic                   take;
	logic                   is_err;
	logic                   full_conds;

	assign is_err     = (state_q == S_ERR);
	assign char_ready = is_err || !q_full;
	assign take       = char_valid && char_ready && !is_err;
	assign nxt        = next_state(state_q, char_code);
	assign full_conds = (cnt_q >= CNT_W'(CAP));

	// Multiply by ten as two shifts and an add, then add the digit
	assign src_nxt = {src_q[NODE_BITS-4:0], 3'b000} + {src_q[NODE_BITS-2:0], 1'b0}
		+ NODE_BITS'(char_code[3:0]);
	assign dst_nxt = {dst_q[NODE_BITS-4:0], 3'b000} + {dst_q[NODE_BITS-2:0], 1'b0}
		+ NODE_BITS'(char_code[3:0]);
	assign cur_nxt = {cur_q[4:0], 3'b000} + {cur_q[6:0], 1'b0} + CHAR_W'(char_code[3:0]);

	assign src_ext = {{NODE_OUT_W{1'b0}}, src_q};
	assign dst_ext = {{NODE_OUT_W{1'b0}}, dst_q};

	// Build the command for this character
	always_comb begin
		q_push       = 1'b0;
		q_cmd.kind   = CMD_COND;
		q_cmd.status = ST_RECORD;
		q_cmd.cond   = cur_q;
		q_cmd.src    = src_ext[NODE_OUT_W-1:0];
		q_cmd.dest   = dst_ext[NODE_OUT_W-1:0];
		if (take) begin
			if (nxt == S_ERR) begin
				q_push       = 1'b1;
				q_cmd.kind   = CMD_ERR;
				q_cmd.status = ST_BAD_CHAR;
			end else if (nxt == S_COMMA || nxt == S_DASH2) begin
				q_push = 1'b1;
				if (full_conds) begin
					q_cmd.kind   = CMD_ERR;
					q_cmd.status = ST_OVERFLOW;
				end
			end else if (nxt == S_SEMI) begin
				q_push     = 1'b1;
				q_cmd.kind = CMD_END;
			end
		end
	end

	// Advance lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LINE;
			src_q   <= '0;
			dst_q   <= '0;
			cur_q   <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			state_q <= nxt;
			if (nxt == S_SRC) src_q <= src_nxt;
			if (nxt == S_QCHAR) cur_q <= char_code;
			if (nxt == S_CODE) cur_q <= cur_nxt;
			if (nxt == S_DST) dst_q <= dst_nxt;
			if (nxt == S_COMMA || nxt == S_DASH2) begin
				if (full_conds) begin
					state_q <= S_ERR;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (nxt == S_COMMA) cur_q <= '0;
				end
			end
			if (nxt == S_SEMI) begin
				src_q <= '0;
				dst_q <= '0;
				cur_q <= '0;
				cnt_q <= '0;
			end
		end
	end

endmodule

/* sv/tlp_queue.sv */
// Short command queue between the lexer front and the record back end.
module tlp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlp_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output tlp_pkg::cmd_t  head
);
	import tlp_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW:0]   wr_q;
	logic [Q_AW:0]   rd_q;

	assign full      = (wr_q[Q_AW] != rd_q[Q_AW]) && (wr_q[Q_AW-1:0] == rd_q[Q_AW-1:0]);
	assign not_empty = (wr_q != rd_q);
	assign head      = mem_q[rd_q[Q_AW-1:0]];

	// Hold entries
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q[Q_AW-1:0]] <= push_cmd;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && not_empty) rd_q <= rd_q + 1'b1;
		end
	end

endmodule

/* sv/tlp_back.sv */
// Record back end: buffers conditions and emits one record per condition, or one error record.
module tlp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  tlp_pkg::cmd_t              q_head,
	output logic                       q_pop,
	output logic                       rec_valid,
	input  logic                       rec_ready,
	output logic [1:0]                 status,
	output logic [15:0]                source_node,
	output logic [7:0]                 condition_byte,
	output logic [15:0]                target_node,
	output logic                       last
);
	import tlp_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_EMIT = 2'b10
	} back_state_t;

	back_state_t             state_q;
	logic [CHAR_W-1:0]       store_q [STORE_DEPTH];
	logic [CNT_W-1:0]        wr_q;
	logic [CNT_W-1:0]        num_q;
	logic [CNT_W-1:0]        k_q;
	logic [NODE_OUT_W-1:0]   src_q;
	logic [NODE_OUT_W-1:0]   dst_q;
	logic                    out_valid_q;
	logic                    slot_free;
	logic                    load_err;
	logic                    load_rec;
	logic                    rec_last;

	assign slot_free = !out_valid_q || rec_ready;
	assign rec_valid = out_valid_q;
	assign rec_last  = ((k_q + 1'b1) == num_q);
	assign load_err  = (state_q == B_IDLE) && q_valid && (q_head.kind == CMD_ERR) && slot_free;
	assign load_rec  = (state_q == B_EMIT) && slot_free;

	// While idle, drop conditions and line ends at once; drop errors once the output slot is free
	always_comb begin
		q_pop = 1'b0;
		if (state_q == B_IDLE && q_valid) begin
			case (q_head.kind)
				CMD_ERR: q_pop = slot_free;
				default: q_pop = 1'b1;
			endcase
		end
	end

	// Hold condition bytes of the current line
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid && q_head.kind == CMD_COND)
			store_q[wr_q[IDX_W-1:0]] <= q_head.cond;
	end

	// Sequence line ends into record runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			wr_q    <= '0;
			num_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_valid && q_head.kind == CMD_COND) begin
						wr_q <= wr_q + 1'b1;
					end else if (q_valid && q_head.kind == CMD_END) begin
						num_q   <= wr_q;
						wr_q    <= '0;
						k_q     <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						k_q <= k_q + 1'b1;
						if (rec_last) state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Latch node numbers at line end
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid && q_head.kind == CMD_END) begin
			src_q <= q_head.src;
			dst_q <= q_head.dest;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_err || load_rec) begin
			out_valid_q <= 1'b1;
		end else if (rec_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_err) begin
			status         <= q_head.status;
			source_node    <= '0;
			condition_byte <= '0;
			target_node    <= '0;
			last           <= 1'b1;
		end else if (load_rec) begin
			status         <= ST_RECORD;
			source_node    <= src_q;
			condition_byte <= store_q[k_q[IDX_W-1:0]];
			target_node    <= dst_q;
			last           <= rec_last;
		end
	end

endmodule

/* sv/transition_list_text_parser_unit.sv */
// Top level of the transition list text parser: front lexer, command queue, record back end.
//
//  channel  dir  handshake              payload
//  char     in   char_valid/char_ready  char_code[7:0]
//  rec      out  rec_valid/rec_ready    status, source_node, condition_byte, target_node, last
//
// The front takes one character per cycle while the four-entry command queue has room.
// A line with N conditions leaves the back end as N records, one per cycle while rec_ready is high,
// after the ';' command reaches the head of the queue; between record runs the back end drains the
// queue one command a cycle, errors once the output slot is free; it pops nothing during a run.
// Reset (arst_n low) returns the lexer to line start and empties the queue and output.
// After an error the front takes and drops every character until reset.
// A stalled rec channel fills the queue, then holds char_ready low unless the front is in error.
module transition_list_text_parser_unit #(
	parameter int MAX_CONDS = 16,
	parameter int NODE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	output logic        rec_valid,
	input  logic        rec_ready,
	output logic [1:0]  status,
	output logic [15:0] source_node,
	output logic [7:0]  condition_byte,
	output logic [15:0] target_node,
	output logic        last
);
	import tlp_pkg::*;

	logic  q_full;
	logic  q_push;
	cmd_t  q_cmd;
	logic  q_pop;
	logic  q_valid;
	cmd_t  q_head;

	tlp_front #(
		.MAX_CONDS (MAX_CONDS),
		.NODE_BITS (NODE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	tlp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	tlp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.rec_valid      (rec_valid),
		.rec_ready      (rec_ready),
		.status         (status),
		.source_node    (source_node),
		.condition_byte (condition_byte),
		.target_node    (target_node),
		.last           (last)
	);

endmodule
